// ===== hdl/swv_pkg.sv =====
// ---------------------------------------------------------------------------
// swv_pkg: shared definitions for the sliding window variance block
// Field widths, queue sizing, divider step size and the sample magnitude
// helper used by the front end.
// ---------------------------------------------------------------------------
package swv_pkg;

  // Payload field widths
  localparam int SAMPLE_W = 24;   // energy sample, signed Q12.12
  localparam int VAR_W    = 47;   // variance, unsigned Q23.24
  localparam int HELD_W   = 7;    // samples held in the window

  // Default window length
  localparam int DEF_WINDOW_DEPTH = 64;

  // Entries in the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // Quotient bits resolved per divider cycle
  localparam int DIV_STEP_BITS = 8;

  // Magnitude of a signed sample; the most negative code maps to 2^23
  function automatic logic [SAMPLE_W-1:0] sample_mag(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] m;
    m = s[SAMPLE_W-1] ? SAMPLE_W'(-s) : SAMPLE_W'(s);
    return m;
  endfunction

endpackage

// ===== hdl/swv_ram.sv =====
// ---------------------------------------------------------------------------
// swv_ram: generic single write, single read RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module swv_ram #(
  parameter  int WIDTH  = 24,
  parameter  int DEPTH  = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/swv_front.sv =====
// ---------------------------------------------------------------------------
// swv_front: sample intake and running sums
// Takes one sample per transaction, retires the oldest sample once the
// window is full, keeps the running sum and sum of squares, and pushes
// |sum|, sum of squares and the sample count into the queue.
// ---------------------------------------------------------------------------
module swv_front import swv_pkg::*; #(
  parameter  int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  localparam int PTR_W = $clog2(WINDOW_DEPTH),
  localparam int N_W   = $clog2(WINDOW_DEPTH + 1),
  localparam int MAG_W = SAMPLE_W + PTR_W,
  localparam int SQ_W  = 2 * SAMPLE_W - 1 + PTR_W
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] energy_sample,
  // queue write side
  output logic                       push,
  input  logic                       push_ready,
  output logic [MAG_W-1:0]           push_mag,
  output logic [SQ_W-1:0]            push_sq,
  output logic [N_W-1:0]             push_n
);

  localparam int SUM_W  = MAG_W + 1;
  localparam int PROD_W = 2 * SAMPLE_W - 1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQ_NEW,
    F_SQ_OLD,
    F_UPDATE,
    F_PUSH
  } front_state_t;

  front_state_t              state;
  logic [PTR_W-1:0]          wp;
  logic [N_W-1:0]            fill;
  logic signed [SUM_W-1:0]   run_sum;
  logic [SQ_W-1:0]           run_sq;
  logic signed [SAMPLE_W-1:0] x;
  logic [PROD_W-1:0]         sq_new;
  logic [PROD_W-1:0]         sq_old;

  logic [SAMPLE_W-1:0]       old_raw;
  logic                      full;
  logic                      ram_we;
  logic [SAMPLE_W-1:0]       mul_in;
  logic [2*SAMPLE_W-1:0]     mul_out;
  logic signed [SUM_W-1:0]   sum_next;
  logic [SQ_W-1:0]           sq_next;

  assign full     = (fill == N_W'(WINDOW_DEPTH));
  assign in_ready = (state == F_IDLE);
  assign ram_we   = (state == F_UPDATE);

  // Sample ring; read address follows the write pointer so the oldest
  // sample is on the read port in the cycle after acceptance
  swv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (x),
    .raddr (wp),
    .rdata (old_raw)
  );

  // Shared squaring multiplier: new sample first, then the retiring one
  always_comb begin
    mul_in  = (state == F_SQ_NEW) ? sample_mag(x) : sample_mag($signed(old_raw));
    mul_out = mul_in * mul_in;
  end

  // Running sum updates; the old sample only counts once the window is full
  always_comb begin
    sum_next = run_sum + SUM_W'(x);
    sq_next  = run_sq + SQ_W'(sq_new);
    if (full) begin
      sum_next = sum_next - SUM_W'($signed(old_raw));
      sq_next  = sq_next - SQ_W'(sq_old);
    end
  end

  // Queue payload straight from the registered sums
  always_comb begin
    push     = (state == F_PUSH);
    push_mag = run_sum[SUM_W-1] ? MAG_W'(-run_sum) : MAG_W'(run_sum);
    push_sq  = run_sq;
    push_n   = fill;
  end

  // Front end sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      wp      <= '0;
      fill    <= '0;
      run_sum <= '0;
      run_sq  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            x     <= energy_sample;
            state <= F_SQ_NEW;
          end
        end
        F_SQ_NEW: begin
          sq_new <= mul_out[PROD_W-1:0];
          state  <= F_SQ_OLD;
        end
        F_SQ_OLD: begin
          sq_old <= mul_out[PROD_W-1:0];
          state  <= F_UPDATE;
        end
        F_UPDATE: begin
          run_sum <= sum_next;
          run_sq  <= sq_next;
          if (!full) begin
            fill <= fill + N_W'(1);
          end
          if (wp == PTR_W'(WINDOW_DEPTH - 1)) begin
            wp <= '0;
          end else begin
            wp <= wp + PTR_W'(1);
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/swv_fifo.sv =====
// ---------------------------------------------------------------------------
// swv_fifo: short queue between front and back end
// Register based, first in first out, with full and empty flags.
// ---------------------------------------------------------------------------
module swv_fifo import swv_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/swv_back.sv =====
// ---------------------------------------------------------------------------
// swv_back: variance evaluation
// Divides the sum of squares and |sum| by n in one shared radix-256 loop,
// squares the mean, subtracts with clamp at zero and holds the result in
// the output register.
// ---------------------------------------------------------------------------
module swv_back import swv_pkg::*; #(
  parameter  int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  localparam int PTR_W = $clog2(WINDOW_DEPTH),
  localparam int N_W   = $clog2(WINDOW_DEPTH + 1),
  localparam int MAG_W = SAMPLE_W + PTR_W,
  localparam int SQ_W  = 2 * SAMPLE_W - 1 + PTR_W
) (
  input  logic              clk,
  input  logic              rst,
  // queue read side
  input  logic              q_valid,
  output logic              q_pop,
  input  logic [MAG_W-1:0]  q_mag,
  input  logic [SQ_W-1:0]   q_sq,
  input  logic [N_W-1:0]    q_n,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAR_W-1:0]  window_variance,
  output logic [HELD_W-1:0] samples_held
);

  localparam int DIV_STEPS = (SQ_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_STEP_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PROD_W    = 2 * SAMPLE_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_SUB
  } back_state_t;

  back_state_t       state;
  logic [CNT_W-1:0]  step_cnt;
  logic [N_W-1:0]    div_n;
  logic [DIV_W-1:0]  dq_sq;
  logic [DIV_W-1:0]  dq_mag;
  logic [N_W-1:0]    rem_sq;
  logic [N_W-1:0]    rem_mag;
  logic [PROD_W-1:0] mean_prod;

  logic [DIV_W-1:0]  dq_sq_next;
  logic [DIV_W-1:0]  dq_mag_next;
  logic [N_W-1:0]    rem_sq_next;
  logic [N_W-1:0]    rem_mag_next;
  logic [N_W:0]      trial_sq;
  logic [N_W:0]      trial_mag;
  logic [SAMPLE_W-1:0] mean_mag;
  logic [PROD_W-1:0] mean_sq_ext;
  logic              out_free;

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign mean_mag = dq_mag[SAMPLE_W-1:0];
  assign mean_sq_ext = PROD_W'(dq_sq[VAR_W-1:0]);
  assign out_free = !out_valid || out_ready;

  // One divider cycle: DIV_STEP_BITS restoring steps on both quotients
  always_comb begin
    dq_sq_next   = dq_sq;
    dq_mag_next  = dq_mag;
    rem_sq_next  = rem_sq;
    rem_mag_next = rem_mag;
    trial_sq     = '0;
    trial_mag    = '0;
    for (int k = 0; k < DIV_STEP_BITS; k++) begin
      trial_sq    = {rem_sq_next, dq_sq_next[DIV_W-1]};
      trial_mag   = {rem_mag_next, dq_mag_next[DIV_W-1]};
      dq_sq_next  = {dq_sq_next[DIV_W-2:0], 1'b0};
      dq_mag_next = {dq_mag_next[DIV_W-2:0], 1'b0};
      if (trial_sq >= {1'b0, div_n}) begin
        rem_sq_next   = N_W'(trial_sq - {1'b0, div_n});
        dq_sq_next[0] = 1'b1;
      end else begin
        rem_sq_next = trial_sq[N_W-1:0];
      end
      if (trial_mag >= {1'b0, div_n}) begin
        rem_mag_next   = N_W'(trial_mag - {1'b0, div_n});
        dq_mag_next[0] = 1'b1;
      end else begin
        rem_mag_next = trial_mag[N_W-1:0];
      end
    end
  end

  // Back end sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drains on acceptance unless a new result takes its place
      if (out_valid && out_ready && state != B_SUB) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            div_n    <= q_n;
            dq_sq    <= DIV_W'(q_sq);
            dq_mag   <= DIV_W'(q_mag);
            rem_sq   <= '0;
            rem_mag  <= '0;
            step_cnt <= CNT_W'(DIV_STEPS - 1);
            state    <= B_DIV;
          end
        end
        B_DIV: begin
          dq_sq    <= dq_sq_next;
          dq_mag   <= dq_mag_next;
          rem_sq   <= rem_sq_next;
          rem_mag  <= rem_mag_next;
          step_cnt <= step_cnt - CNT_W'(1);
          if (step_cnt == '0) begin
            state <= B_MUL;
          end
        end
        B_MUL: begin
          mean_prod <= mean_mag * mean_mag;
          state     <= B_SUB;
        end
        B_SUB: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            samples_held <= HELD_W'(div_n);
            if (mean_sq_ext > mean_prod) begin
              window_variance <= VAR_W'(mean_sq_ext - mean_prod);
            end else begin
              window_variance <= '0;
            end
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/sliding_window_variance.sv =====
// ---------------------------------------------------------------------------
// sliding_window_variance: variance over the last WINDOW_DEPTH samples
// Front end keeps the sample ring and running sums, back end divides by n,
// squares the mean and clamps the difference at zero.
// ---------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------
//  input   | in_valid / in_ready    | energy_sample   (24b signed Q12.12)
//  output  | out_valid / out_ready  | window_variance (47b Q23.24),
//          |                        | samples_held    (7b)
//
//  Front end takes one sample at a time (accept, two squarings on one
//  shared multiplier, sum update, queue push that waits for room).
//  Back end takes one queue entry at a time through the radix-256 divider
//  loop, mean squaring and subtract, and the loop sets the sustained rate.
//  Reset clears pointers, counts and sums; ring contents only enter the sums
//  once written. The queue lets the front end run on while results stall.
//
module sliding_window_variance import swv_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] energy_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [VAR_W-1:0]           window_variance,
  output logic [HELD_W-1:0]          samples_held
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int N_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int MAG_W = SAMPLE_W + PTR_W;
  localparam int SQ_W  = 2 * SAMPLE_W - 1 + PTR_W;
  localparam int Q_W   = MAG_W + SQ_W + N_W;

  logic             push;
  logic             push_ready;
  logic [MAG_W-1:0] push_mag;
  logic [SQ_W-1:0]  push_sq;
  logic [N_W-1:0]   push_n;
  logic             q_pop;
  logic             q_valid;
  logic [Q_W-1:0]   q_data;

  // Intake and running sums
  swv_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .energy_sample (energy_sample),
    .push          (push),
    .push_ready    (push_ready),
    .push_mag      (push_mag),
    .push_sq       (push_sq),
    .push_n        (push_n)
  );

  // Work queue
  swv_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  ({push_mag, push_sq, push_n}),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  // Division, mean square and clamp
  swv_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_mag           (q_data[Q_W-1 -: MAG_W]),
    .q_sq            (q_data[N_W +: SQ_W]),
    .q_n             (q_data[N_W-1:0]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .window_variance (window_variance),
    .samples_held    (samples_held)
  );

endmodule

// ===== hdl/swv_checker.sv =====
// ---------------------------------------------------------------------------
// swv_checker: port level checks for sliding_window_variance
// Tracks transactions in flight and the expected window fill, bound to the
// top level.
// ---------------------------------------------------------------------------
module swv_checker import swv_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [VAR_W-1:0]    window_variance,
  input logic [HELD_W-1:0]   samples_held
);

  // front, queue, back end and output register
  localparam int INFLIGHT_MAX = QUEUE_DEPTH + 3;
  localparam int OUT_W = $clog2(INFLIGHT_MAX + 2);
  localparam int N_W   = $clog2(WINDOW_DEPTH + 1);

  logic [OUT_W-1:0] outstanding;
  logic [N_W-1:0]   delivered;
  logic [HELD_W-1:0] expected_held;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign expected_held = (delivered == N_W'(WINDOW_DEPTH)) ? HELD_W'(delivered)
                                                            : HELD_W'(delivered + N_W'(1));

  // Transactions in flight and results delivered (saturating at the depth)
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      delivered   <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        outstanding <= outstanding + OUT_W'(1);
      end else if (out_acc && !in_acc) begin
        outstanding <= outstanding - OUT_W'(1);
      end
      if (out_acc && delivered != N_W'(WINDOW_DEPTH)) begin
        delivered <= delivered + N_W'(1);
      end
    end
  end

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_variance)
                               && $stable(samples_held))
    else $error("result changed while stalled");

  // No result without a sample behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != '0)
    else $error("result with no sample outstanding");

  // Pipeline never holds more than its capacity
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    outstanding <= OUT_W'(INFLIGHT_MAX))
    else $error("too many samples in flight");

  // Window fill grows by one per result until the window is full
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> samples_held == expected_held)
    else $error("samples_held out of sequence");

  // Output channel empty straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_variance swv_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_swv_checker (.*);

// ===== tb/sv/tb_sliding_window_variance.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sliding_window_variance: self-checking bench for the window variance
// Drives signed Q12.12 samples over a valid/ready channel, keeps its own
// ring, running sum and sum of squares, and checks every variance and
// sample count that comes back, in order, field by field.
// ---------------------------------------------------------------------------
module tb_sliding_window_variance import swv_pkg::*; ();

  localparam int DEPTH = DEF_WINDOW_DEPTH;
  localparam int RANDOM_ITEMS = 700;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // Shapes of the random sample bursts
  typedef enum int {
    MIX_UNIFORM,
    MIX_CLUSTER,
    MIX_CONSTANT,
    MIX_ALTERNATE,
    MIX_EXTREME
  } sample_mix_t;

  typedef struct packed {
    logic [VAR_W-1:0]  variance;
    logic [HELD_W-1:0] held;
  } variance_result_t;

  typedef struct packed {
    logic                       known;
    logic signed [SAMPLE_W-1:0] sample;
    logic [VAR_W-1:0]           variance;
    logic [HELD_W-1:0]          held;
  } directed_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] energy_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [VAR_W-1:0]           window_variance;
  logic [HELD_W-1:0]          samples_held;

  // Window state of the predictor
  logic signed [SAMPLE_W-1:0] win_ring [DEPTH];
  int unsigned                win_ptr = 0;
  int unsigned                win_held = 0;
  longint                     win_sum = 0;
  longint unsigned            win_sq_sum = 0;

  variance_result_t pending_variance [$];
  int unsigned      mismatch_count = 0;
  logic             steady_flow = 1'b0;

  // Directed samples; typed results only where they are obvious
  directed_row_t directed_rows [0:17] = '{
    '{1'b1, SAMPLE_MIN,    47'd0, 7'd1},   // first sample after reset
    '{1'b1, SAMPLE_MIN,    47'd0, 7'd2},   // equal samples, no spread
    '{1'b0, SAMPLE_MAX,    47'd0, 7'd0},   // widest swing
    '{1'b0, SAMPLE_MAX,    47'd0, 7'd0},
    '{1'b0, 24'sh000000,   47'd0, 7'd0},
    '{1'b0, 24'sh000001,   47'd0, 7'd0},
    '{1'b0, 24'shFFFFFF,   47'd0, 7'd0},
    '{1'b0, 24'sh555555,   47'd0, 7'd0},
    '{1'b0, 24'shAAAAAA,   47'd0, 7'd0},
    '{1'b0, 24'sh000FFF,   47'd0, 7'd0},
    '{1'b0, 24'shFFF000,   47'd0, 7'd0},
    '{1'b0, 24'sh7FF000,   47'd0, 7'd0},
    '{1'b0, 24'sh800FFF,   47'd0, 7'd0},
    '{1'b0, 24'sh001000,   47'd0, 7'd0},
    '{1'b0, 24'sh001000,   47'd0, 7'd0},
    '{1'b0, 24'sh001000,   47'd0, 7'd0},
    '{1'b0, 24'sh400000,   47'd0, 7'd0},
    '{1'b0, 24'shC00000,   47'd0, 7'd0}
  };

  sliding_window_variance #(
    .WINDOW_DEPTH(DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .energy_sample   (energy_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .window_variance (window_variance),
    .samples_held    (samples_held)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Square of a sample magnitude, exact in 64 bits
  function automatic longint unsigned sample_square(input logic signed [SAMPLE_W-1:0] s);
    longint unsigned mag;
    mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    return mag * mag;
  endfunction

  // Advance the window by one sample and return the variance it reports
  function automatic variance_result_t next_variance(input logic signed [SAMPLE_W-1:0] s);
    variance_result_t res;
    longint unsigned  n;
    longint unsigned  mean_square;
    longint unsigned  sum_mag;
    longint unsigned  mean_mag;
    longint unsigned  mean_sq;
    longint unsigned  diff;
    // full window: drop the oldest sample first
    if (win_held >= DEPTH) begin
      win_sum    = win_sum - longint'(win_ring[win_ptr]);
      win_sq_sum = win_sq_sum - sample_square(win_ring[win_ptr]);
      win_held   = DEPTH;
    end else begin
      win_held++;
    end
    win_ring[win_ptr] = s;
    win_sum    = win_sum + longint'(s);
    win_sq_sum = win_sq_sum + sample_square(s);
    win_ptr    = (win_ptr + 1 >= DEPTH) ? 0 : win_ptr + 1;

    // divide by samples actually held, clamp at zero
    n           = win_held;
    mean_square = win_sq_sum / n;
    sum_mag     = (win_sum < 0) ? longint'(-win_sum) : longint'(win_sum);
    mean_mag    = sum_mag / n;
    mean_sq     = mean_mag * mean_mag;
    diff        = (mean_square > mean_sq) ? mean_square - mean_sq : 64'd0;
    res.variance = diff[VAR_W-1:0];
    res.held     = n[HELD_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Present one sample and wait for the transaction, with random gaps
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic known,
                             input variance_result_t typed);
    variance_result_t predicted;
    while (!steady_flow && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    energy_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = next_variance(s);
    pending_variance.push_back(known ? typed : predicted);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_variance.size() != 0);
  endtask

  // Result side: random back-pressure and in-order checking
  always @(posedge clk) begin
    variance_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_variance.size() == 0) begin
          report_mismatch("unexpected result, variance", window_variance, 0);
        end else begin
          want = pending_variance.pop_front();
          if (window_variance !== want.variance)
            report_mismatch("window_variance", window_variance, want.variance);
          if (samples_held !== want.held)
            report_mismatch("samples_held", samples_held, want.held);
        end
      end
      out_ready <= steady_flow || ($urandom_range(99) >= 6);
    end
  end

  // Stimulus
  initial begin
    int                         sent;
    int                         burst;
    int                         k;
    sample_mix_t                mix;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] s;
    variance_result_t           typed;

    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: warm-up with extremes and equal samples
    foreach (directed_rows[r]) begin
      typed.variance = directed_rows[r].variance;
      typed.held     = directed_rows[r].held;
      send_sample(directed_rows[r].sample, directed_rows[r].known, typed);
    end
    drain_results();

    // random bursts; the window fills and wraps many times
    typed = '0;
    while (sent < RANDOM_ITEMS) begin
      mix   = sample_mix_t'($urandom_range(MIX_EXTREME, MIX_UNIFORM));
      burst = $urandom_range(80, 1);
      base  = SAMPLE_W'($urandom);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        case (mix)
          MIX_UNIFORM:   s = SAMPLE_W'($urandom);
          MIX_CLUSTER:   s = base + SAMPLE_W'($urandom_range(255)) - 24'sd128;
          MIX_CONSTANT:  s = base;
          MIX_ALTERNATE: s = k[0] ? SAMPLE_MAX : SAMPLE_MIN;
          MIX_EXTREME:   s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
          default:       s = '0;
        endcase
        // long stretch at full rate on both sides
        steady_flow <= (sent >= 200 && sent < 400);
        send_sample(s, 1'b0, typed);
        sent++;
        if (sent == RANDOM_ITEMS / 2)
          drain_results();
      end
    end
    in_valid <= 1'b0;
    steady_flow <= 1'b0;

    // let the pipeline empty, then watch for stray results
    while (pending_variance.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_sliding_window_variance passed");
    else
      $display("tb_sliding_window_variance failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_sliding_window_variance failed");
    $finish;
  end

endmodule
